/* design/dch_pkg.sv */
// ----------------------------------------------------------------------------
// dch_pkg
// shared constants, control word layout and microprogram of the
// dominance count histogram core
// ----------------------------------------------------------------------------
package dch_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int UPC_W      = 4;

  // action codes of an input word
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_IDLE,
    OP_ZERO_I,
    OP_CLR_BIN,
    OP_RD_I,
    OP_LATCH_I,
    OP_CMP,
    OP_HRD,
    OP_HWR,
    OP_SET_VALID,
    OP_RD_BIN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_READ,
    C_HIST_VALID,
    C_N_ZERO,
    C_I_NOT_LAST_BIN,
    C_J_MORE,
    C_I_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } ctrl_t;

  typedef struct packed {
    logic no_read;
    logic hist_valid;
    logic n_zero;
    logic i_not_last_bin;
    logic j_more;
    logic i_more;
    logic out_free;
  } flags_t;

  // step addresses
  localparam logic [UPC_W-1:0] S_IDLE       = 4'd0;
  localparam logic [UPC_W-1:0] S_CHK        = 4'd1;
  localparam logic [UPC_W-1:0] S_CLR_INIT   = 4'd2;
  localparam logic [UPC_W-1:0] S_CLR        = 4'd3;
  localparam logic [UPC_W-1:0] S_OUTER_INIT = 4'd4;
  localparam logic [UPC_W-1:0] S_RD_I       = 4'd5;
  localparam logic [UPC_W-1:0] S_LATCH_I    = 4'd6;
  localparam logic [UPC_W-1:0] S_CMP        = 4'd7;
  localparam logic [UPC_W-1:0] S_HRD        = 4'd8;
  localparam logic [UPC_W-1:0] S_HWR        = 4'd9;
  localparam logic [UPC_W-1:0] S_DONE       = 4'd10;
  localparam logic [UPC_W-1:0] S_FETCH      = 4'd11;
  localparam logic [UPC_W-1:0] S_EMIT       = 4'd12;
  localparam logic [UPC_W-1:0] S_WAIT       = 4'd13;

  // microprogram: when the condition holds go to target, else next step
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    unique case (addr)
      S_IDLE:       w = '{op: OP_IDLE,      cond: C_NO_READ,        target: S_IDLE};
      S_CHK:        w = '{op: OP_NONE,      cond: C_HIST_VALID,     target: S_FETCH};
      S_CLR_INIT:   w = '{op: OP_ZERO_I,    cond: C_ALWAYS,         target: S_CLR};
      S_CLR:        w = '{op: OP_CLR_BIN,   cond: C_I_NOT_LAST_BIN, target: S_CLR};
      S_OUTER_INIT: w = '{op: OP_ZERO_I,    cond: C_N_ZERO,         target: S_DONE};
      S_RD_I:       w = '{op: OP_RD_I,      cond: C_ALWAYS,         target: S_LATCH_I};
      S_LATCH_I:    w = '{op: OP_LATCH_I,   cond: C_ALWAYS,         target: S_CMP};
      S_CMP:        w = '{op: OP_CMP,       cond: C_J_MORE,         target: S_CMP};
      S_HRD:        w = '{op: OP_HRD,       cond: C_ALWAYS,         target: S_HWR};
      S_HWR:        w = '{op: OP_HWR,       cond: C_I_MORE,         target: S_RD_I};
      S_DONE:       w = '{op: OP_SET_VALID, cond: C_ALWAYS,         target: S_FETCH};
      S_FETCH:      w = '{op: OP_RD_BIN,    cond: C_ALWAYS,         target: S_EMIT};
      S_EMIT:       w = '{op: OP_EMIT,      cond: C_OUT_FREE,       target: S_IDLE};
      S_WAIT:       w = '{op: OP_NONE,      cond: C_ALWAYS,         target: S_EMIT};
      default:      w = '{op: OP_NONE,      cond: C_ALWAYS,         target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* design/dch_seq.sv */
// ----------------------------------------------------------------------------
// dch_seq
// step counter and microprogram table with conditional jumps
// ----------------------------------------------------------------------------
module dch_seq (
  input  logic            clk,
  input  logic            rst,
  input  dch_pkg::flags_t flags,
  output dch_pkg::ctrl_t  ctrl
);
  import dch_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             take;

  assign ctrl = ucode(upc);

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:         take = 1'b1;
      C_NO_READ:        take = flags.no_read;
      C_HIST_VALID:     take = flags.hist_valid;
      C_N_ZERO:         take = flags.n_zero;
      C_I_NOT_LAST_BIN: take = flags.i_not_last_bin;
      C_J_MORE:         take = flags.j_more;
      C_I_MORE:         take = flags.i_more;
      C_OUT_FREE:       take = flags.out_free;
      default:          take = 1'b1;
    endcase
    upc_next = take ? ctrl.target : upc + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

/* design/dch_dp.sv */
// ----------------------------------------------------------------------------
// dch_dp
// point store, histogram memory, loop counters and pair compare
// ----------------------------------------------------------------------------
module dch_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  dch_pkg::ctrl_t            ctrl,
  input  logic                      in_fire,
  input  logic                      out_free,
  input  logic [1:0]                action,
  input  logic [15:0]               coord_x,
  input  logic [15:0]               coord_y,
  input  logic [15:0]               coord_z,
  input  logic [5:0]                level,
  output dch_pkg::flags_t           flags,
  output logic [dch_pkg::CNT_W-1:0] res_bin,
  output logic                      res_bad,
  output logic                      res_ovf
);
  import dch_pkg::*;

  logic [PT_W-1:0]  pstore [MAX_POINTS];
  logic [CNT_W-1:0] hist   [MAX_POINTS];

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             hvalid;
  logic [5:0]       level_r;
  logic [IDX_W-1:0] i;
  logic [CNT_W-1:0] j;
  logic [IDX_W-1:0] jd;
  logic [IDX_W-1:0] cnt;
  logic [PT_W-1:0]  pi;
  logic [PT_W-1:0]  pt_rdata;
  logic [CNT_W-1:0] h_rdata;

  logic             p_we;
  logic             p_re;
  logic [IDX_W-1:0] p_raddr;
  logic             h_we;
  logic [IDX_W-1:0] h_waddr;
  logic [CNT_W-1:0] h_wdata;
  logic             h_re;
  logic [IDX_W-1:0] h_raddr;
  logic             covers;
  logic [CNT_W-1:0] last;

  assign last = count - CNT_W'(1);

  // point j (read data) lies at or below point i on all three axes
  assign covers =
    (pt_rdata[PT_W-1 -: COORD_BITS]         <= pi[PT_W-1 -: COORD_BITS]) &&
    (pt_rdata[2*COORD_BITS-1 -: COORD_BITS] <= pi[2*COORD_BITS-1 -: COORD_BITS]) &&
    (pt_rdata[COORD_BITS-1:0]               <= pi[COORD_BITS-1:0]);

  always_comb begin
    p_we    = (ctrl.op == OP_IDLE) && in_fire && (action == ACT_LOAD) &&
              (count < CNT_W'(MAX_POINTS));
    p_re    = 1'b0;
    p_raddr = j[IDX_W-1:0];
    h_we    = 1'b0;
    h_waddr = i;
    h_wdata = '0;
    h_re    = 1'b0;
    h_raddr = cnt;
    unique case (ctrl.op)
      OP_RD_I: begin
        p_re    = 1'b1;
        p_raddr = i;
      end
      OP_LATCH_I, OP_CMP: begin
        p_re = 1'b1;
      end
      OP_CLR_BIN: begin
        h_we = 1'b1;
      end
      OP_HRD: begin
        h_re = 1'b1;
      end
      OP_HWR: begin
        h_we    = 1'b1;
        h_waddr = cnt;
        h_wdata = h_rdata + CNT_W'(1);
      end
      OP_RD_BIN: begin
        h_re    = 1'b1;
        h_raddr = level_r[IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (p_we) begin
      pstore[count[IDX_W-1:0]] <= {coord_x[COORD_BITS-1:0], coord_y[COORD_BITS-1:0],
                                   coord_z[COORD_BITS-1:0]};
    end
    if (p_re) begin
      pt_rdata <= pstore[p_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rdata <= hist[h_raddr];
    end
  end

  // set state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      ovf    <= 1'b0;
      hvalid <= 1'b0;
    end else if (ctrl.op == OP_IDLE && in_fire) begin
      if (action == ACT_LOAD) begin
        if (count < CNT_W'(MAX_POINTS)) begin
          count  <= count + CNT_W'(1);
          hvalid <= 1'b0;
        end else begin
          ovf <= 1'b1;
        end
      end else if (action == ACT_CLEAR) begin
        count  <= '0;
        ovf    <= 1'b0;
        hvalid <= 1'b0;
      end
    end else if (ctrl.op == OP_SET_VALID) begin
      hvalid <= 1'b1;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (in_fire && action == ACT_READ) begin
          level_r <= level;
        end
      end
      OP_ZERO_I: begin
        i <= '0;
      end
      OP_CLR_BIN: begin
        i <= i + IDX_W'(1);
      end
      OP_RD_I: begin
        j   <= '0;
        cnt <= '0;
      end
      OP_LATCH_I: begin
        pi <= pt_rdata;
        jd <= j[IDX_W-1:0];
        j  <= j + CNT_W'(1);
      end
      OP_CMP: begin
        if (jd != i && covers) begin
          cnt <= cnt + IDX_W'(1);
        end
        jd <= j[IDX_W-1:0];
        j  <= j + CNT_W'(1);
      end
      OP_HWR: begin
        i <= i + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign flags.no_read        = !(in_fire && action == ACT_READ);
  assign flags.hist_valid     = hvalid;
  assign flags.n_zero         = (count == '0);
  assign flags.i_not_last_bin = (i != IDX_W'(MAX_POINTS - 1));
  assign flags.j_more         = ({1'b0, jd} != last);
  assign flags.i_more         = ({1'b0, i} != last);
  assign flags.out_free       = out_free;

  assign res_bad = ({1'b0, level_r} >= count);
  assign res_bin = res_bad ? '0 : h_rdata;
  assign res_ovf = ovf;

endmodule

/* design/dominance_count_histogram_core.sv */
// ----------------------------------------------------------------------------
// dominance_count_histogram_core
// histogram of 3-d dominance counts over a loaded point set
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one word carries action, coord_x/y/z
//   and level. load stores a point (dropped and flagged once 64 are held),
//   clear empties the set, read asks for one histogram bin.
//   output channel (out_valid/out_ready): one word per read with bin_count,
//   bad_level (level not below the point count, bin_count then zero) and
//   overflow (a load was dropped since the last clear).
// timing
//   load, clear and unused action codes are handled at the idle step itself.
//   a read on an unchanged set passes the check, fetch and emit steps before out_valid.
//   the first read after a change first rebuilds the histogram for n points:
//   a clear of all 64 bins, three setup steps, and per point a read, a latch,
//   n compares through the single point store read port, a bin read and write.
//   one word is handled at a time; in_ready is high only at the idle step.
// reset and stall
//   rst (synchronous) empties the set, clears overflow and marks the
//   histogram stale; the point store itself is not cleared.
//   the result sits in an output register; while the receiver stalls the
//   block still takes loads and clears, a second read waits for the slot.
// ----------------------------------------------------------------------------
module dominance_count_histogram_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] coord_x,
  input  logic [15:0] coord_y,
  input  logic [15:0] coord_z,
  input  logic [5:0]  level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  bin_count,
  output logic        bad_level,
  output logic        overflow
);
  import dch_pkg::*;

  ctrl_t            ctrl;
  flags_t           flags;
  logic             in_fire;
  logic             out_free;
  logic             emit;
  logic [CNT_W-1:0] res_bin;
  logic             res_bad;
  logic             res_ovf;

  // words are taken only at the idle step of the microprogram
  assign in_ready = (ctrl.op == OP_IDLE);
  assign in_fire  = in_valid && in_ready;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  assign emit     = (ctrl.op == OP_EMIT) && out_free;

  dch_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dch_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_fire  (in_fire),
    .out_free (out_free),
    .action   (action),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .coord_z  (coord_z),
    .level    (level),
    .flags    (flags),
    .res_bin  (res_bin),
    .res_bad  (res_bad),
    .res_ovf  (res_ovf)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bin_count <= res_bin;
      bad_level <= res_bad;
      overflow  <= res_ovf;
    end
  end

endmodule

/* design/dch_chk.sv */
// ----------------------------------------------------------------------------
// dch_chk
// port-level checks of the dominance count histogram core
// ----------------------------------------------------------------------------
module dch_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  action,
  input logic        out_valid,
  input logic        out_ready,
  input logic [6:0]  bin_count,
  input logic        bad_level,
  input logic        overflow
);
  import dch_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_count) &&
      $stable(bad_level) && $stable(overflow))
    else $error("stalled result word changed");

  // an out-of-range level never carries a count
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_level |-> bin_count == 7'd0)
    else $error("bad level with nonzero count");

  // no bin can exceed the point capacity
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count <= 7'(MAX_POINTS))
    else $error("bin count above capacity");

  // reset empties the output slot
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // an accepted read keeps the input closed for the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_READ |=> !in_ready)
    else $error("input open right after a read");

endmodule

bind dominance_count_histogram_core dch_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .action    (action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .bin_count (bin_count),
  .bad_level (bad_level),
  .overflow  (overflow)
);
